@@ design/ocss_pkg.sv @@
// shared constants, register map, mode and opcode codes, timer result type
`timescale 1ns / 1ps

package ocss_pkg;

  localparam int DEFAULT_POSITION_BITS = 24;
  localparam int LIMIT_BITS            = 23;
  localparam int TIMER_BITS            = 32;
  localparam int ELAPSED_BITS          = 16;
  localparam int OPCODE_BITS           = 2;
  localparam int MODE_BITS             = 3;
  // enable, carriage step, direction, mirror step, table step, mode, running
  localparam int STATUS_BITS           = 6 + MODE_BITS;

  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_BITS-1:0] REG_POSITIVE_LIMIT = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_NEGATIVE_LIMIT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CARRIAGE_PERIOD = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_MIRROR_PERIOD = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_TABLE_PERIOD = 3'd4;

  localparam logic [LIMIT_BITS-1:0] POSITIVE_LIMIT_RST  = 23'd1;
  localparam logic [LIMIT_BITS-1:0] NEGATIVE_LIMIT_RST  = 23'd1;
  localparam logic [TIMER_BITS-1:0] CARRIAGE_PERIOD_RST = 32'd1000;
  localparam logic [TIMER_BITS-1:0] MIRROR_PERIOD_RST   = 32'd1;
  localparam logic [TIMER_BITS-1:0] TABLE_PERIOD_RST    = 32'd1;

  localparam logic [OPCODE_BITS-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_RUN    = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_STOP   = 2'd2;
  localparam logic [OPCODE_BITS-1:0] OP_FINISH = 2'd3;

  localparam logic [MODE_BITS-1:0] MODE_INIT      = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_IDLE      = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_RUN       = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_FINISHING = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_STOP      = 3'd4;

  typedef struct packed {
    logic [TIMER_BITS-1:0] count;
    logic                  fire;
  } timer_out_t;

endpackage

@@ design/ocss_timer.sv @@
// saturating period timer: adds elapsed time, fires and clears at its period
`timescale 1ns / 1ps

module ocss_timer (
  input  logic                             en,
  input  logic [ocss_pkg::TIMER_BITS-1:0]   count,
  input  logic [ocss_pkg::ELAPSED_BITS-1:0] elapsed_us,
  input  logic [ocss_pkg::TIMER_BITS-1:0]   period,
  output ocss_pkg::timer_out_t             result
);
  import ocss_pkg::*;

  logic [TIMER_BITS:0]   sum;
  logic [TIMER_BITS-1:0] sat;
  logic                  fire;

  assign sum  = {1'b0, count} + (TIMER_BITS + 1)'(elapsed_us);
  assign sat  = sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
  assign fire = en && (sat >= period);

  assign result.fire  = fire;
  assign result.count = !en ? count : (fire ? '0 : sat);

endmodule

@@ design/oscillating_carriage_stepper_sequencer_core.sv @@
// top level: command decode, carriage sweep, three period timers, config regs
`timescale 1ns / 1ps

// Sequencer for one oscillating carriage and two free-running rotators
// (mirror and table). Each input beat carries an opcode in s_tuser (tick, run,
// stop, finish) and elapsed microseconds in s_tdata; every input beat gives
// exactly one result beat with the enable, step pulses, direction, mode and
// carriage position after that beat. Throughput is one beat per clock while
// m_tready is high; the whole update is done between the state registers
// and the result register, and the longest path is the 32-bit saturating add
// and period compare of the carriage timer feeding the position update. The
// result register holds a beat while m_tready is low; s_tready stays high
// whenever that register is empty or being drained in the same cycle.
// Configuration goes through the APB port (byte address 4 * index) and should
// only be written while the block is idle.

module oscillating_carriage_stepper_sequencer_core #(
  parameter  int POSITION_BITS = ocss_pkg::DEFAULT_POSITION_BITS,
  localparam int DATA_BITS     = ((ocss_pkg::STATUS_BITS + POSITION_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ocss_pkg::ELAPSED_BITS-1:0]  s_tdata,   // [15:0] elapsed_us
  input  logic [ocss_pkg::OPCODE_BITS-1:0]   s_tuser,   // [1:0] opcode
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // drive_enable, carriage_step, carriage_forward, mirror_step, table_step,
  // mode[2:0], running, carriage_position, zero pad (lowest bit up)
  output logic [DATA_BITS-1:0]               m_tdata,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ocss_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [ocss_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [ocss_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import ocss_pkg::*;

  // limits are compared at the wider of the limit and position widths
  localparam int CMP_BITS = (POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS;
  localparam logic [CMP_BITS-1:0] POS_TOP =
    CMP_BITS'((64'd1 << (POSITION_BITS - 1)) - 64'd1);

  // config registers
  logic [LIMIT_BITS-1:0] positive_limit;
  logic [LIMIT_BITS-1:0] negative_limit;
  logic [TIMER_BITS-1:0] carriage_period;
  logic [TIMER_BITS-1:0] mirror_interval;
  logic [TIMER_BITS-1:0] table_interval;

  // sequencer state
  logic [MODE_BITS-1:0]            mode, mode_next;
  logic                            enable, enable_next;
  logic signed [POSITION_BITS-1:0] position, position_next;
  logic                            forward, forward_next;
  logic [TIMER_BITS-1:0]           carriage_timer;
  logic [TIMER_BITS-1:0]           mirror_count;
  logic [TIMER_BITS-1:0]           table_count;

  logic                    accept;
  logic                    active;
  logic                    tick_en;
  logic                    carriage_step;
  logic                    running_next;
  timer_out_t              carriage_res;
  timer_out_t              mirror_res;
  timer_out_t              table_res;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    cfg_write;

  logic [CMP_BITS-1:0]             plim_wide, nlim_wide;
  logic signed [POSITION_BITS-1:0] plim, nlim_neg;
  logic                            pos_side;
  logic                            fwd_turned;
  logic signed [POSITION_BITS-1:0] pos_moved;

  // ---------------------------------------------------------------------------
  // config port, always ready, decoded on the word index
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[REG_IDX_BITS+1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      positive_limit  <= POSITIVE_LIMIT_RST;
      negative_limit  <= NEGATIVE_LIMIT_RST;
      carriage_period <= CARRIAGE_PERIOD_RST;
      mirror_interval <= MIRROR_PERIOD_RST;
      table_interval  <= TABLE_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_POSITIVE_LIMIT:  positive_limit  <= pwdata[LIMIT_BITS-1:0];
        REG_NEGATIVE_LIMIT:  negative_limit  <= pwdata[LIMIT_BITS-1:0];
        REG_CARRIAGE_PERIOD: carriage_period <= pwdata;
        REG_MIRROR_PERIOD:   mirror_interval <= pwdata;
        REG_TABLE_PERIOD:    table_interval  <= pwdata;
        default: ;  // unmapped addresses are ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POSITIVE_LIMIT:  prdata = CFG_DATA_BITS'(positive_limit);
      REG_NEGATIVE_LIMIT:  prdata = CFG_DATA_BITS'(negative_limit);
      REG_CARRIAGE_PERIOD: prdata = carriage_period;
      REG_MIRROR_PERIOD:   prdata = mirror_interval;
      REG_TABLE_PERIOD:    prdata = table_interval;
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: a new beat goes in whenever the result register frees up
  // ---------------------------------------------------------------------------
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign active  = (mode == MODE_RUN) || (mode == MODE_FINISHING);
  assign tick_en = (s_tuser == OP_TICK) && active;

  // ---------------------------------------------------------------------------
  // timers, only advanced by a tick while moving
  // ---------------------------------------------------------------------------
  ocss_timer u_carriage_timer (
    .en         (tick_en),
    .count      (carriage_timer),
    .elapsed_us (s_tdata),
    .period     (carriage_period),
    .result     (carriage_res)
  );

  ocss_timer u_mirror_count (
    .en         (tick_en),
    .count      (mirror_count),
    .elapsed_us (s_tdata),
    .period     (mirror_interval),
    .result     (mirror_res)
  );

  ocss_timer u_table_count (
    .en         (tick_en),
    .count      (table_count),
    .elapsed_us (s_tdata),
    .period     (table_interval),
    .result     (table_res)
  );

  // ---------------------------------------------------------------------------
  // carriage sweep: limits clamped to the position range, turn then step
  // ---------------------------------------------------------------------------
  assign plim_wide = (CMP_BITS'(positive_limit) > POS_TOP) ? POS_TOP : CMP_BITS'(positive_limit);
  assign nlim_wide = (CMP_BITS'(negative_limit) > POS_TOP) ? POS_TOP : CMP_BITS'(negative_limit);
  assign plim      = $signed(plim_wide[POSITION_BITS-1:0]);
  assign nlim_neg  = -$signed(nlim_wide[POSITION_BITS-1:0]);

  // zero counts as the positive side when heading forward
  assign pos_side = (position > 0) || ((position == 0) && forward);

  always_comb begin
    fwd_turned = forward;
    if (pos_side) begin
      if (forward && (position >= plim)) fwd_turned = 1'b0;
    end else begin
      if (!forward && (position <= nlim_neg)) fwd_turned = 1'b1;
    end
  end

  assign pos_moved = fwd_turned ? position + POSITION_BITS'(1) : position - POSITION_BITS'(1);

  // ---------------------------------------------------------------------------
  // command decode and next state
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_next     = mode;
    enable_next   = enable;
    position_next = position;
    forward_next  = forward;
    carriage_step = 1'b0;
    unique case (s_tuser)
      OP_TICK: begin
        if (tick_en && carriage_res.fire) begin
          if ((mode == MODE_FINISHING) && (position == 0)) begin
            // back home: park without stepping
            mode_next   = MODE_IDLE;
            enable_next = 1'b0;
          end else begin
            forward_next  = fwd_turned;
            position_next = pos_moved;
            carriage_step = 1'b1;
          end
        end
      end
      OP_RUN: begin
        if (!active) begin
          mode_next    = MODE_RUN;
          enable_next  = 1'b1;
          forward_next = 1'b1;
        end
      end
      OP_STOP: begin
        mode_next   = MODE_STOP;
        enable_next = 1'b0;
      end
      OP_FINISH: begin
        if (mode == MODE_RUN) begin
          if (position != 0) begin
            mode_next = MODE_FINISHING;
          end else begin
            mode_next   = MODE_IDLE;
            enable_next = 1'b0;
          end
        end
      end
    endcase
  end

  assign running_next = (mode_next == MODE_RUN) || (mode_next == MODE_FINISHING);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_INIT;
      enable         <= 1'b0;
      position       <= '0;
      forward        <= 1'b1;
      carriage_timer <= '0;
      mirror_count   <= '0;
      table_count    <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      enable         <= enable_next;
      position       <= position_next;
      forward        <= forward_next;
      carriage_timer <= carriage_res.count;
      mirror_count   <= mirror_res.count;
      table_count    <= table_res.count;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= DATA_BITS'({position_next, running_next, mode_next, table_res.fire,
                             mirror_res.fire, forward_next, carriage_step, enable_next});
    end
  end

endmodule

@@ design/ocss_checker.sv @@
// port-level checks on the sequencer result stream, bound to the top level
`timescale 1ns / 1ps

module ocss_checker #(
  parameter  int POSITION_BITS = ocss_pkg::DEFAULT_POSITION_BITS,
  localparam int DATA_BITS     = ((ocss_pkg::STATUS_BITS + POSITION_BITS + 7) / 8) * 8
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [DATA_BITS-1:0] m_tdata
);
  import ocss_pkg::*;

  logic                 drive_enable;
  logic                 carriage_step;
  logic [MODE_BITS-1:0] mode;
  logic                 running;

  assign drive_enable  = m_tdata[0];
  assign carriage_step = m_tdata[1];
  assign mode          = m_tdata[7:5];
  assign running       = m_tdata[8];

  // a held result beat does not change
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // a stalled full result register blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while result register full");

  // drivers are on exactly while moving
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (drive_enable == ((mode == MODE_RUN) || (mode == MODE_FINISHING))))
    else $error("drive enable disagrees with mode");

  // a carriage step leaves the sequencer running
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && carriage_step |-> running)
    else $error("carriage stepped outside run or finishing");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind oscillating_carriage_stepper_sequencer_core ocss_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_ocss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
